// File: src/cmos_rtc_register_surface_core_macros.svh
// ----------------------------------------------------------------------------
// CMOS RTC register surface: assertion macros
// Shared implication checks, clocked and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef CMOS_RTC_REGISTER_SURFACE_CORE_MACROS_SVH
`define CMOS_RTC_REGISTER_SURFACE_CORE_MACROS_SVH

// same-cycle implication
`define CRRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crrs: same-cycle check failed");

// next-cycle implication
`define CRRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crrs: next-cycle check failed");

`endif

// File: src/crrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_pkg
// Types, register indexes and constants of the CMOS RTC register surface.
// ----------------------------------------------------------------------------
package crrs_pkg;

    localparam int AddrW       = 7;
    localparam int ByteW       = 8;
    localparam int KbW         = 22;
    localparam int StoreDepth  = 1 << AddrW;

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [ByteW-1:0] t_byte;
    typedef logic [KbW-1:0]   t_kb;

    // bus access codes
    localparam logic CmdRead   = 1'b0;
    localparam logic CmdWrite  = 1'b1;
    localparam logic PortIndex = 1'b0;
    localparam logic PortData  = 1'b1;

    // register indexes
    localparam t_addr IdxWeekday = 7'h06;
    localparam t_addr IdxDate    = 7'h07;
    localparam t_addr IdxMonth   = 7'h08;
    localparam t_addr IdxYear    = 7'h09;
    localparam t_addr IdxA       = 7'h0A;
    localparam t_addr IdxB       = 7'h0B;
    localparam t_addr IdxC       = 7'h0C;
    localparam t_addr IdxD       = 7'h0D;
    localparam t_addr IdxBaseLo  = 7'h15;
    localparam t_addr IdxBaseHi  = 7'h16;
    localparam t_addr IdxExtLo   = 7'h17;
    localparam t_addr IdxExtHi   = 7'h18;
    localparam t_addr IdxExt2Lo  = 7'h30;
    localparam t_addr IdxExt2Hi  = 7'h31;
    localparam t_addr IdxCentury = 7'h32;
    localparam t_addr IdxHiLo    = 7'h34;
    localparam t_addr IdxHiHi    = 7'h35;
    localparam t_addr IdxAlias   = 7'h37;

    // register bits
    localparam t_byte BitUip    = 8'h80;
    localparam t_byte BitSet    = 8'h80;
    localparam t_byte BitUie    = 8'h10;
    localparam t_byte BitIrqf   = 8'h80;
    localparam t_byte SrcMask   = 8'h70;
    localparam t_byte IndexRead = 8'hFF;

    // reset contents
    localparam t_byte RstA       = 8'h26;
    localparam t_byte RstB       = 8'h02;
    localparam t_byte RstC       = 8'h00;
    localparam t_byte RstD       = 8'h80;
    localparam t_byte RstWeekday = 8'h06;
    localparam t_byte RstDate    = 8'h05;
    localparam t_byte RstMonth   = 8'h06;
    localparam t_byte RstYear    = 8'h26;
    localparam t_byte RstCentury = 8'h20;

    // memory-size seeding: 640 KB base, extended counts saturate at 16 bits
    localparam logic [15:0] BaseKb     = 16'h0280;
    localparam logic [15:0] ExtCap     = 16'hFFFF;
    localparam int          LowMemKb   = 1024;
    localparam int          HighMemKb  = 16 * 1024;
    localparam int          HiBlockSh  = 6;
    localparam t_kb         HiStartKb  = KbW'(HighMemKb - LowMemKb);

    typedef struct packed {
        logic  command;
        logic  port_select;
        t_byte write_data;
    } t_req;

    typedef struct packed {
        t_byte read_data;
        logic  irq_level;
        logic  nmi_mask;
    } t_rsp;

    // access leaving the input register
    typedef struct packed {
        logic  fire;
        logic  command;
        logic  port_select;
        t_addr eff;
        t_byte write_data;
    } t_access;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_byte data;
    } t_mem_wr;

    // reset value of plain store bytes
    function automatic t_byte store_reset(input t_addr a);
        t_byte v;
        case (a)
            IdxWeekday: v = RstWeekday;
            IdxDate:    v = RstDate;
            IdxMonth:   v = RstMonth;
            IdxYear:    v = RstYear;
            IdxCentury: v = RstCentury;
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/crrs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_store
// 128-byte general store: one write port, one registered read port, valid
// bits for reset contents, write-to-read bypass.
// ----------------------------------------------------------------------------
module crrs_store
    import crrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rd_en,
    input  t_addr   i_rd_addr,
    input  t_mem_wr i_wr,
    output t_byte   o_rd_data
);

    t_byte                 r_mem [StoreDepth];
    logic [StoreDepth-1:0] r_vld;
    t_byte                 r_rd_raw;
    logic                  r_rd_vld;
    logic                  r_fwd;
    t_byte                 r_fwd_data;
    t_addr                 r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_raw   <= r_mem[i_rd_addr];
            r_rd_vld   <= r_vld[i_rd_addr];
            r_fwd      <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_fwd_data <= i_wr.data;
            r_rd_addr  <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // unwritten entries read as their reset byte
    assign o_rd_data = r_fwd    ? r_fwd_data :
                       r_rd_vld ? r_rd_raw   : store_reset(r_rd_addr);

endmodule

// File: src/crrs_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_regs
// Control registers A-D, interrupt line, memory-size bytes and the
// per-register data access rules.
// ----------------------------------------------------------------------------
`include "cmos_rtc_register_surface_core_macros.svh"

module crrs_regs
    import crrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_access i_acc,
    input  t_byte   i_mem_data,
    input  logic    i_cfg_valid,
    input  t_kb     i_cfg_data,
    output t_byte   o_read_data,
    output logic    o_irq,
    output t_mem_wr o_mem_wr
);

    t_byte r_reg_a, r_reg_b, r_reg_c, r_reg_d;
    logic  r_irq;
    t_byte r_base_lo, r_base_hi, r_ext_lo, r_ext_hi;
    t_byte r_ext2_lo, r_ext2_hi, r_hi_lo, r_hi_hi;

    t_byte n_reg_a, n_reg_b, n_reg_c, n_reg_d;
    logic  n_irq;
    t_byte n_base_lo, n_base_hi, n_ext_lo, n_ext_hi;
    t_byte n_ext2_lo, n_ext2_hi, n_hi_lo, n_hi_hi;

    logic        is_write, is_data;
    t_byte       cur_val, new_b;
    logic        kb_zero, kb_high;
    t_kb         kb_over;
    logic [15:0] seed_ext, seed_hi, seed_base;

    assign is_write = (i_acc.command == CmdWrite);
    assign is_data  = (i_acc.port_select == PortData);

    // memory-size seed from the config value
    assign kb_zero   = (i_cfg_data == '0);
    assign kb_high   = (i_cfg_data > HiStartKb);
    assign kb_over   = i_cfg_data - HiStartKb;
    assign seed_ext  = (|i_cfg_data[KbW-1:16]) ? ExtCap : i_cfg_data[15:0];
    assign seed_hi   = kb_high ? kb_over[KbW-1:HiBlockSh] : '0;
    assign seed_base = kb_zero ? '0 : BaseKb;

    always_comb begin
        n_reg_a   = r_reg_a;
        n_reg_b   = r_reg_b;
        n_reg_c   = r_reg_c;
        n_reg_d   = r_reg_d;
        n_irq     = r_irq;
        n_base_lo = r_base_lo;
        n_base_hi = r_base_hi;
        n_ext_lo  = r_ext_lo;
        n_ext_hi  = r_ext_hi;
        n_ext2_lo = r_ext2_lo;
        n_ext2_hi = r_ext2_hi;
        n_hi_lo   = r_hi_lo;
        n_hi_hi   = r_hi_hi;
        new_b     = i_acc.write_data;
        o_mem_wr  = '{en: 1'b0, addr: i_acc.eff, data: i_acc.write_data};

        case (i_acc.eff)
            IdxA:      cur_val = r_reg_a & ~BitUip;
            IdxB:      cur_val = r_reg_b;
            IdxC:      cur_val = r_reg_c;
            IdxD:      cur_val = r_reg_d;
            IdxBaseLo: cur_val = r_base_lo;
            IdxBaseHi: cur_val = r_base_hi;
            IdxExtLo:  cur_val = r_ext_lo;
            IdxExtHi:  cur_val = r_ext_hi;
            IdxExt2Lo: cur_val = r_ext2_lo;
            IdxExt2Hi: cur_val = r_ext2_hi;
            IdxHiLo:   cur_val = r_hi_lo;
            IdxHiHi:   cur_val = r_hi_hi;
            default:   cur_val = i_mem_data;
        endcase

        if (is_write) begin
            o_read_data = '0;
        end else if (is_data) begin
            o_read_data = cur_val;
        end else begin
            o_read_data = IndexRead;
        end

        if (i_acc.fire && is_data) begin
            if (!is_write) begin
                // read of C clears flags and drops the line
                if (i_acc.eff == IdxC) begin
                    n_reg_c = '0;
                    n_irq   = 1'b0;
                end
            end else begin
                case (i_acc.eff)
                    IdxA: begin
                        n_reg_a = (i_acc.write_data & ~BitUip) | (r_reg_a & BitUip);
                    end
                    IdxB: begin
                        if ((i_acc.write_data & BitSet) != '0) begin
                            new_b = i_acc.write_data & ~BitUie;
                        end
                        n_reg_b = new_b;
                        if ((new_b & r_reg_c & SrcMask) != '0) begin
                            n_reg_c = r_reg_c | BitIrqf;
                            n_irq   = 1'b1;
                        end else begin
                            n_reg_c = r_reg_c & ~BitIrqf;
                            n_irq   = 1'b0;
                        end
                    end
                    IdxC, IdxD: begin
                    end
                    IdxBaseLo: n_base_lo = i_acc.write_data;
                    IdxBaseHi: n_base_hi = i_acc.write_data;
                    IdxExtLo:  n_ext_lo  = i_acc.write_data;
                    IdxExtHi:  n_ext_hi  = i_acc.write_data;
                    IdxExt2Lo: n_ext2_lo = i_acc.write_data;
                    IdxExt2Hi: n_ext2_hi = i_acc.write_data;
                    IdxHiLo:   n_hi_lo   = i_acc.write_data;
                    IdxHiHi:   n_hi_hi   = i_acc.write_data;
                    default:   o_mem_wr.en = 1'b1;
                endcase
            end
        end
    end

    assign o_irq = n_irq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_a   <= RstA;
            r_reg_b   <= RstB;
            r_reg_c   <= RstC;
            r_reg_d   <= RstD;
            r_irq     <= 1'b0;
            r_base_lo <= '0;
            r_base_hi <= '0;
            r_ext_lo  <= '0;
            r_ext_hi  <= '0;
            r_ext2_lo <= '0;
            r_ext2_hi <= '0;
            r_hi_lo   <= '0;
            r_hi_hi   <= '0;
        end else begin
            r_reg_a <= n_reg_a;
            r_reg_b <= n_reg_b;
            r_reg_c <= n_reg_c;
            r_reg_d <= n_reg_d;
            r_irq   <= n_irq;
            if (i_cfg_valid) begin
                r_base_lo <= seed_base[7:0];
                r_base_hi <= seed_base[15:8];
                r_ext_lo  <= seed_ext[7:0];
                r_ext_hi  <= seed_ext[15:8];
                r_ext2_lo <= seed_ext[7:0];
                r_ext2_hi <= seed_ext[15:8];
                r_hi_lo   <= seed_hi[7:0];
                r_hi_hi   <= seed_hi[15:8];
            end else begin
                r_base_lo <= n_base_lo;
                r_base_hi <= n_base_hi;
                r_ext_lo  <= n_ext_lo;
                r_ext_hi  <= n_ext_hi;
                r_ext2_lo <= n_ext2_lo;
                r_ext2_hi <= n_ext2_hi;
                r_hi_lo   <= n_hi_lo;
                r_hi_hi   <= n_hi_hi;
            end
        end
    end

    `CRRS_ASSERT_NOW(a_irq_tracks_irqf, i_clk, i_rst_n, 1'b1, r_irq == r_reg_c[7])
    `CRRS_ASSERT_NEXT(a_c_read_clears, i_clk, i_rst_n, i_acc.fire && !is_write && is_data && (i_acc.eff == IdxC), (r_reg_c == '0) && !r_irq)
    `CRRS_ASSERT_NEXT(a_set_drops_uie, i_clk, i_rst_n, i_acc.fire && is_write && is_data && (i_acc.eff == IdxB) && i_acc.write_data[7], !r_reg_b[4])

endmodule

// File: src/cmos_rtc_register_surface_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmos_rtc_register_surface_core
// Index/data register surface over a 128-byte clock and CMOS store.
//
//   channel   dir  handshake                   payload
//   -------   ---  --------------------------  ------------------------
//   request   in   i_req_valid / o_req_ready   i_req (t_req)
//   response  out  o_rsp_valid / i_rsp_ready   o_rsp (t_rsp)
//   config    in   i_cfg_valid / o_cfg_ready   i_cfg_data (22-bit KB)
//
// One request per cycle while o_req_ready is high; the input register and the
// store read register load together at the accepting edge, and the result
// register and o_rsp_valid load when the input stage advances, which waits
// while a held response occupies the result register.
// Synchronous active-low reset loads device defaults; no clearing pass,
// store bytes carry valid bits.
// A stalled response holds the result register; one more request can sit in
// the input stage before o_req_ready drops.
// ----------------------------------------------------------------------------
`include "cmos_rtc_register_surface_core_macros.svh"

module cmos_rtc_register_surface_core
    import crrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  t_kb  i_cfg_data
);

    // index latch and NMI mask advance at acceptance, so the store read
    // address is known at the accepting edge
    t_addr r_index, n_index;
    logic  r_nmi, n_nmi;

    // input stage
    logic  r_s1_valid;
    logic  r_s1_command;
    logic  r_s1_port;
    t_addr r_s1_eff;
    t_byte r_s1_wd;
    logic  r_s1_nmi;

    // result register
    logic  r_out_valid;
    t_rsp  r_out;

    logic    req_fire, s1_adv;
    t_addr   eff_idx;
    t_access acc;
    t_byte   mem_data, rd_data;
    logic    irq_next;
    t_mem_wr mem_wr;

    assign s1_adv      = r_s1_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_s1_valid || s1_adv;
    assign req_fire    = i_req_valid && o_req_ready;
    assign o_cfg_ready = 1'b1;

    // index 0x37 is an alias of the century byte
    assign eff_idx = (r_index == IdxAlias) ? IdxCentury : r_index;

    always_comb begin
        n_index = r_index;
        n_nmi   = r_nmi;
        if (req_fire) begin
            if (i_req.port_select == PortIndex) begin
                if (i_req.command == CmdWrite) begin
                    n_index = i_req.write_data[AddrW-1:0];
                    n_nmi   = i_req.write_data[ByteW-1];
                end
            end else begin
                n_index = eff_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_nmi       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_index <= n_index;
            r_nmi   <= n_nmi;
            if (req_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1_command <= i_req.command;
            r_s1_port    <= i_req.port_select;
            r_s1_eff     <= eff_idx;
            r_s1_wd      <= i_req.write_data;
            r_s1_nmi     <= n_nmi;
        end
        if (s1_adv) begin
            r_out <= '{read_data: rd_data, irq_level: irq_next, nmi_mask: r_s1_nmi};
        end
    end

    assign acc = '{fire:        s1_adv,
                   command:     r_s1_command,
                   port_select: r_s1_port,
                   eff:         r_s1_eff,
                   write_data:  r_s1_wd};

    crrs_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (req_fire),
        .i_rd_addr (eff_idx),
        .i_wr      (mem_wr),
        .o_rd_data (mem_data)
    );

    crrs_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_mem_data  (mem_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_read_data (rd_data),
        .o_irq       (irq_next),
        .o_mem_wr    (mem_wr)
    );

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    `CRRS_ASSERT_NEXT(a_alias_resolved, i_clk, i_rst_n,
        req_fire && (i_req.port_select == PortData), r_index != IdxAlias)
    `CRRS_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, r_s1_valid && !r_out_valid, r_out_valid)
    `CRRS_ASSERT_NEXT(a_s1_held, i_clk, i_rst_n,
        r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_eff))

endmodule

// File: tb/cmos_rtc_register_surface_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmos_rtc_register_surface_core_test
// Self-checking bench for the CMOS RTC index/data register surface. A short
// stimulus table walks the register rules, then random index/data request
// sequences run under several memory-size settings, with random idling on
// both channels and one long response hold-off. Every response is checked
// field by field against a pinned reply or a cycle-free 128-byte store model.
// ----------------------------------------------------------------------------
module cmos_rtc_register_surface_core_test;
    import crrs_pkg::*;

    // one row of the directed table; pinned rows carry a hand-typed response
    typedef struct packed {
        t_req req;
        logic pinned;
        t_rsp rsp;
    } t_plan_row;

    localparam int NumPlan     = 26;
    localparam int NumPhases   = 8;
    localparam int PhaseItems  = 72;
    localparam int WatchLimit  = 3000;
    localparam int LongHold    = 90;

    // directed walk from reset: index port, register A/B/C/D rules, alias,
    // NMI bit and field extremes
    localparam t_plan_row DirPlan [NumPlan] = '{
        '{'{CmdRead,  PortIndex, 8'h00},         1'b1, '{IndexRead,  1'b0, 1'b0}},
        '{'{CmdWrite, PortIndex, {1'b0, IdxA}},  1'b1, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdRead,  PortData,  8'hFF},         1'b1, '{RstA,       1'b0, 1'b0}},
        '{'{CmdWrite, PortData,  8'hFF},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdRead,  PortData,  8'h00},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdWrite, PortIndex, {1'b1, IdxB}},  1'b1, '{8'h00,      1'b0, 1'b1}},
        '{'{CmdRead,  PortData,  8'h00},         1'b1, '{RstB,       1'b0, 1'b1}},
        '{'{CmdWrite, PortData,  8'h90},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdRead,  PortData,  8'h00},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdWrite, PortData,  8'h7F},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdWrite, PortIndex, {1'b0, IdxC}},  1'b1, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdWrite, PortData,  8'h55},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdRead,  PortData,  8'h00},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdWrite, PortIndex, {1'b0, IdxD}},  1'b1, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdWrite, PortData,  8'h00},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdRead,  PortData,  8'h00},         1'b1, '{RstD,       1'b0, 1'b0}},
        '{'{CmdWrite, PortIndex, {1'b0, IdxAlias}}, 1'b1, '{8'h00,   1'b0, 1'b0}},
        '{'{CmdRead,  PortData,  8'h00},         1'b1, '{RstCentury, 1'b0, 1'b0}},
        '{'{CmdWrite, PortData,  8'hAA},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdWrite, PortIndex, {1'b0, IdxAlias}}, 1'b1, '{8'h00,   1'b0, 1'b0}},
        '{'{CmdWrite, PortData,  8'h5A},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdRead,  PortData,  8'h00},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdWrite, PortIndex, 8'hFF},         1'b1, '{8'h00,      1'b0, 1'b1}},
        '{'{CmdWrite, PortData,  8'h00},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdRead,  PortData,  8'h00},         1'b0, '{8'h00,      1'b0, 1'b0}},
        '{'{CmdRead,  PortIndex, 8'h00},         1'b1, '{IndexRead,  1'b0, 1'b1}}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_kb  i_cfg_data;

    // model state: store image, latched index, NMI bit, interrupt line
    t_byte cmos_image [StoreDepth];
    t_addr latched_index;
    logic  nmi_held;
    logic  irq_held;

    t_rsp        replies_due [$];   // responses owed, oldest first
    int unsigned requests_sent;
    int unsigned mismatches;

    // idling controls, set by the stimulus process
    bit req_idle_on;
    bit rsp_idle_on;
    bit long_hold_go;

    cmos_rtc_register_surface_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model of one bus access; updates the image and returns the response.
    // ------------------------------------------------------------------
    function automatic t_rsp rtc_access(input t_req r);
        t_rsp  o;
        t_addr eff;
        t_byte nb;
        o   = '0;
        // a latched alias index resolves to the century byte on data access
        eff = (latched_index == IdxAlias) ? IdxCentury : latched_index;
        if (r.command == CmdRead) begin
            if (r.port_select == PortIndex) begin
                o.read_data = IndexRead;        // index port reads all ones
            end else begin
                latched_index = eff;
                o.read_data   = cmos_image[eff];
                if (eff == IdxA) begin
                    o.read_data = o.read_data & ~BitUip;
                end
                if (eff == IdxC) begin
                    // clear-on-read, also drops the line
                    cmos_image[IdxC] = '0;
                    irq_held         = 1'b0;
                end
            end
        end else if (r.port_select == PortIndex) begin
            latched_index = r.write_data[AddrW-1:0];
            nmi_held      = r.write_data[ByteW-1];
        end else begin
            case (eff)
                IdxA: begin
                    // update-in-progress stays as stored
                    cmos_image[IdxA] = (r.write_data & ~BitUip) |
                                       (cmos_image[IdxA] & BitUip);
                end
                IdxB: begin
                    nb = r.write_data;
                    if ((nb & BitSet) != '0) begin
                        nb = nb & ~BitUie;
                    end
                    cmos_image[IdxB] = nb;
                    if ((nb & cmos_image[IdxC] & SrcMask) != '0) begin
                        cmos_image[IdxC] = cmos_image[IdxC] | BitIrqf;
                        irq_held         = 1'b1;
                    end else begin
                        cmos_image[IdxC] = cmos_image[IdxC] & ~BitIrqf;
                        irq_held         = 1'b0;
                    end
                end
                IdxC, IdxD: begin
                    // read-only registers, write dropped
                end
                default: begin
                    cmos_image[eff] = r.write_data;
                end
            endcase
            latched_index = eff;
        end
        o.irq_level = irq_held;
        o.nmi_mask  = nmi_held;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Memory-size bytes after a write of the size register.
    // ------------------------------------------------------------------
    function automatic void apply_memory_size(input t_kb kb);
        int unsigned total;
        int unsigned ext;
        int unsigned hi;
        logic        base;
        total = LowMemKb + int'(kb);
        ext   = (kb > ExtCap) ? ExtCap : kb;
        hi    = (total > HighMemKb) ? ((total - HighMemKb) >> HiBlockSh) : 0;
        if (hi > ExtCap) begin
            hi = ExtCap;
        end
        base = (kb != '0);
        if (!base) begin
            ext = 0;
            hi  = 0;
        end
        cmos_image[IdxBaseLo] = base ? BaseKb[7:0]  : 8'h00;
        cmos_image[IdxBaseHi] = base ? BaseKb[15:8] : 8'h00;
        cmos_image[IdxExtLo]  = ext[7:0];
        cmos_image[IdxExtHi]  = ext[15:8];
        cmos_image[IdxExt2Lo] = ext[7:0];
        cmos_image[IdxExt2Hi] = ext[15:8];
        cmos_image[IdxHiLo]   = hi[7:0];
        cmos_image[IdxHiHi]   = hi[15:8];
    endfunction

    // ------------------------------------------------------------------
    // Offer one request, optionally after an idle burst, and log the
    // response it owes once the block takes it.
    // ------------------------------------------------------------------
    task automatic issue_request(input t_req r, input logic pinned, input t_rsp pin_rsp);
        int unsigned gap;
        t_rsp        owed;
        gap = 0;
        if (req_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
        end
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        owed = rtc_access(r);
        replies_due.push_back(pinned ? pin_rsp : owed);
        requests_sent++;
    endtask

    // Register index with a bias toward the ones that carry special rules.
    function automatic t_addr pick_index();
        t_addr ix;
        case ($urandom_range(0, 11))
            0:       ix = IdxA;
            1:       ix = IdxB;
            2:       ix = IdxC;
            3:       ix = IdxD;
            4, 5:    ix = IdxAlias;
            6:       ix = IdxCentury;
            7, 8: begin
                case ($urandom_range(0, 7))
                    0:       ix = IdxBaseLo;
                    1:       ix = IdxBaseHi;
                    2:       ix = IdxExtLo;
                    3:       ix = IdxExtHi;
                    4:       ix = IdxExt2Lo;
                    5:       ix = IdxExt2Hi;
                    6:       ix = IdxHiLo;
                    default: ix = IdxHiHi;
                endcase
            end
            9:       ix = ($urandom_range(0, 1) != 0) ? 7'h7F : 7'h00;
            default: ix = t_addr'($urandom_range(0, StoreDepth - 1));
        endcase
        return ix;
    endfunction

    // ------------------------------------------------------------------
    // Random traffic: mostly an index write followed by a few data
    // accesses, the rest index-port reads, stray data accesses and noise.
    // ------------------------------------------------------------------
    task automatic run_traffic(input int unsigned count);
        int unsigned goal;
        int unsigned burst;
        t_req        r;
        goal = requests_sent + count;
        while (requests_sent < goal) begin
            case ($urandom_range(0, 9))
                7: begin
                    r.command     = CmdRead;
                    r.port_select = PortIndex;
                    r.write_data  = t_byte'($urandom);
                    issue_request(r, 1'b0, '0);
                end
                8: begin
                    r.command     = $urandom_range(0, 1) ? CmdWrite : CmdRead;
                    r.port_select = PortData;
                    r.write_data  = t_byte'($urandom);
                    issue_request(r, 1'b0, '0);
                end
                9: begin
                    r.command     = $urandom_range(0, 1) ? CmdWrite : CmdRead;
                    r.port_select = $urandom_range(0, 1) ? PortData : PortIndex;
                    r.write_data  = t_byte'($urandom);
                    issue_request(r, 1'b0, '0);
                end
                default: begin
                    r.command     = CmdWrite;
                    r.port_select = PortIndex;
                    r.write_data  = {1'($urandom_range(0, 1)), pick_index()};
                    issue_request(r, 1'b0, '0);
                    burst = $urandom_range(1, 3);
                    repeat (burst) begin
                        r.command     = $urandom_range(0, 1) ? CmdWrite : CmdRead;
                        r.port_select = PortData;
                        r.write_data  = t_byte'($urandom);
                        issue_request(r, 1'b0, '0);
                    end
                end
            endcase
        end
        i_req_valid <= 1'b0;
    endtask

    // Size register write, only once the block has nothing in flight.
    task automatic load_memory_size(input t_kb kb);
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= kb;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_memory_size(kb);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall bursts, plus one long hold-off on
    // request from the stimulus so the pipeline fills and back-pressures.
    // ------------------------------------------------------------------
    initial begin : reply_side
        int unsigned stall;
        bit          hold_taken;
        stall       = 0;
        hold_taken  = 1'b0;
        i_rsp_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                stall      = LongHold;
            end
            if (stall != 0) begin
                i_rsp_ready <= 1'b0;
                stall--;
            end else if (rsp_idle_on && $urandom_range(0, 11) == 0) begin
                i_rsp_ready <= 1'b0;
                stall = $urandom_range(1, 17) - 1;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response check against the oldest owed response.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : reply_check
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected response, expected none, actual %h",
                         $time, o_rsp);
            end else begin
                want = replies_due.pop_front();
                if (o_rsp !== want) begin
                    mismatches++;
                    if (o_rsp.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, o_rsp.read_data);
                    end
                    if (o_rsp.irq_level !== want.irq_level) begin
                        $display("%0t: irq_level expected %b actual %b",
                                 $time, want.irq_level, o_rsp.irq_level);
                    end
                    if (o_rsp.nmi_mask !== want.nmi_mask) begin
                        $display("%0t: nmi_mask expected %b actual %b",
                                 $time, want.nmi_mask, o_rsp.nmi_mask);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no request, response or size write taken.
    always @(posedge i_clk) begin : watchdog
        int unsigned quiet;
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WatchLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, then random phases per size.
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_kb sizes [NumPhases];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_req_valid   = 1'b0;
        i_req         = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        requests_sent = 0;
        mismatches    = 0;
        req_idle_on   = 1'b1;
        rsp_idle_on   = 1'b1;
        long_hold_go  = 1'b0;

        // store image after reset: zeros, device defaults, seeded date
        for (int a = 0; a < StoreDepth; a++) begin
            cmos_image[a] = '0;
        end
        cmos_image[IdxA]       = RstA;
        cmos_image[IdxB]       = RstB;
        cmos_image[IdxC]       = RstC;
        cmos_image[IdxD]       = RstD;
        cmos_image[IdxWeekday] = RstWeekday;
        cmos_image[IdxDate]    = RstDate;
        cmos_image[IdxMonth]   = RstMonth;
        cmos_image[IdxYear]    = RstYear;
        cmos_image[IdxCentury] = RstCentury;
        latched_index = '0;
        nmi_held      = 1'b0;
        irq_held      = 1'b0;

        // size settings: top of range, smallest, around the 16 MB line,
        // around the 16-bit caps, a random one, and back to zero
        sizes[0] = KbW'(4193280);
        sizes[1] = KbW'(1);
        sizes[2] = HiStartKb;
        sizes[3] = HiStartKb + KbW'(64);
        sizes[4] = KbW'(65535);
        sizes[5] = KbW'(65536);
        sizes[6] = KbW'($urandom_range(2, 4193279));
        sizes[7] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DirPlan[i]) begin
            issue_request(DirPlan[i].req, DirPlan[i].pinned, DirPlan[i].rsp);
        end
        i_req_valid <= 1'b0;

        for (int p = 0; p < NumPhases; p++) begin
            load_memory_size(sizes[p]);
            if (p == 2) begin
                long_hold_go = 1'b1;        // long response hold-off
            end
            if (p == NumPhases - 1) begin
                req_idle_on = 1'b0;         // tail runs at full rate
                rsp_idle_on = 1'b0;
            end
            run_traffic(PhaseItems);
        end

        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/crrs_pkg.sv
src/crrs_store.sv
src/crrs_regs.sv
src/cmos_rtc_register_surface_core.sv
tb/cmos_rtc_register_surface_core_test.sv
